// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the filter modules.
// MTLAF_ASSERT checks only while out of reset; MTLAF_ASSERT_RST checks on every edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MTLAF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define MTLAF_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTLAF_ASSERT(lbl, clk, rstn, prop, msg)
`define MTLAF_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/core/mtlaf_pkg.sv
`timescale 1ns / 1ps
package mtlaf_pkg;

  localparam int WINDOW = 5;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int RANK_W = $clog2(WINDOW + 1);
  localparam int TARGET = WINDOW / 2;

  localparam logic [15:0] GAIN_RESET = 16'd6554;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic signed [15:0] sample_t;
  typedef logic signed [23:0] acc_t;

  // Window write controls.
  typedef struct packed {
    logic    fill;    // write every slot, restart the ring
    logic    push;    // overwrite the oldest slot
    sample_t sample;
  } win_wr_t;

  // Smoothing unit controls.
  typedef struct packed {
    logic    mul_en;  // register gain * (median*256 - acc)
    logic    load_en; // commit the new accumulator
    logic    first;   // load accumulator straight from the median
    sample_t median;
  } smooth_ctl_t;

endpackage

// File: rtl/core/mtlaf_in_if.sv
`timescale 1ns / 1ps
interface mtlaf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_alt;

  modport source (output valid, output sample_alt, input ready);
  modport sink   (input valid, input sample_alt, output ready);
endinterface

// File: rtl/core/mtlaf_out_if.sv
`timescale 1ns / 1ps
interface mtlaf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] median_alt;
  logic signed [15:0] smoothed_altitude;
  logic               first_sample;

  modport source (output valid, output median_alt, output smoothed_altitude,
                  output first_sample, input ready);
  modport sink   (input valid, input median_alt, input smoothed_altitude,
                  input first_sample, output ready);
endinterface

// File: rtl/core/mtlaf_window.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mtlaf_window import mtlaf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  win_wr_t wr,
  input  slot_t   cand,
  output sample_t cand_value,
  output logic    cand_hit
);

  sample_t win_r [WINDOW];
  slot_t   oldest_r, oldest_nxt;

  always_comb begin
    oldest_nxt = oldest_r;
    if (wr.fill) begin
      oldest_nxt = '0;
    end else if (wr.push) begin
      if (oldest_r == slot_t'(WINDOW - 1)) begin
        oldest_nxt = '0;
      end else begin
        oldest_nxt = oldest_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
    end else begin
      oldest_r <= oldest_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WINDOW; i++) begin
      if (wr.fill || (wr.push && oldest_r == slot_t'(i))) begin
        win_r[i] <= wr.sample;
      end
    end
  end

  // Rank of the candidate: entries below it, ties broken by slot number.
  always_comb begin
    logic [RANK_W-1:0] rank;
    rank = '0;
    cand_value = win_r[cand];
    for (int j = 0; j < WINDOW; j++) begin
      if ((win_r[j] < cand_value) ||
          (win_r[j] == cand_value && slot_t'(j) < cand)) begin
        rank = rank + 1'b1;
      end
    end
    cand_hit = (rank == RANK_W'(TARGET));
  end

  `MTLAF_ASSERT(a_oldest_range, clk, rst_n, (oldest_r <= slot_t'(WINDOW - 1)), "oldest slot out of range")

endmodule

// File: rtl/core/mtlaf_smooth.sv
`timescale 1ns / 1ps
module mtlaf_smooth import mtlaf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] gain,
  input  smooth_ctl_t ctl,
  output sample_t     smoothed_nxt
);

  // acc' = acc + floor(gain * (median*256 - acc) / 2^16), exact form of the blend.
  acc_t                acc_r, acc_nxt;
  logic signed [41:0]  prod_r;
  logic signed [24:0]  diff;
  logic signed [16:0]  gain_s;
  logic signed [25:0]  sum;

  assign gain_s = $signed({1'b0, gain});
  assign diff   = $signed({ctl.median[15], ctl.median, 8'h00}) - $signed({acc_r[23], acc_r});
  assign sum    = $signed({{2{acc_r[23]}}, acc_r}) + $signed(prod_r[41:16]);

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.load_en) begin
      if (ctl.first) begin
        acc_nxt = {ctl.median, 8'h00};
      end else begin
        acc_nxt = sum[23:0];
      end
    end
  end

  assign smoothed_nxt = acc_nxt[23:8];

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= 42'(gain_s * diff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// File: rtl/core/median_then_lowpass_altitude_filter.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Altitude filter: upper median over a five-sample moving window, then
// first-order exponential smoothing of that median.
// Input channel in_ch: one beat carries sample_alt (signed Q8.8 metres).
// Result channel out_ch: one beat per input beat with median_alt,
// smoothed_altitude (both Q8.8) and first_sample.
// Configuration: cfg_we writes cfg_wdata into the smoothing gain (Q0.16,
// reset 6554, about 0.1). Write it only while the filter is idle.
// Steps: a later sample is written into the window, then the rank scan runs
// (one candidate per cycle through the shared comparator row), then the
// multiplier, then the commit; the next beat is taken the cycle after the
// commit. The first sample after reset fills the window and skips scan and
// multiply.
// The filter holds one sample at a time; in_ch.ready is high only when idle.
// Reset clears the ring pointer, the primed flag and the accumulator and
// returns the gain to 6554; the window contents stay unknown until the first
// sample fills them.
// A stalled receiver leaves the result in the output register; the next
// sample is still taken and runs until its commit, then holds there.
module median_then_lowpass_altitude_filter import mtlaf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  mtlaf_in_if.sink     in_ch,
  mtlaf_out_if.source  out_ch,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RANK = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]  state_r, state_nxt;
  slot_t       cand_r, cand_nxt;
  sample_t     median_r, median_nxt;
  logic        first_r, first_nxt;
  logic        primed_r, primed_nxt;
  logic [15:0] gain_r;

  logic        out_valid_r, out_valid_nxt;
  sample_t     out_median_r, out_smooth_r;
  logic        out_first_r;

  logic        accept, out_free, commit;
  win_wr_t     win_wr;
  smooth_ctl_t sm_ctl;
  sample_t     cand_value, smoothed_nxt;
  logic        cand_hit;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign commit      = (state_r == ST_DONE) && out_free;

  // Window write: fill on the first sample, otherwise push over the oldest slot.
  assign win_wr.fill   = accept && !primed_r;
  assign win_wr.push   = accept && primed_r;
  assign win_wr.sample = in_ch.sample_alt;

  assign sm_ctl.mul_en  = (state_r == ST_MUL);
  assign sm_ctl.load_en = commit;
  assign sm_ctl.first   = first_r;
  assign sm_ctl.median  = median_r;

  mtlaf_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (win_wr),
    .cand       (cand_r),
    .cand_value (cand_value),
    .cand_hit   (cand_hit)
  );

  mtlaf_smooth u_smooth (
    .clk          (clk),
    .rst_n        (rst_n),
    .gain         (gain_r),
    .ctl          (sm_ctl),
    .smoothed_nxt (smoothed_nxt)
  );

  // Sequencer: enter, scan one candidate per cycle, multiply, commit.
  always_comb begin
    state_nxt  = state_r;
    cand_nxt   = cand_r;
    median_nxt = median_r;
    first_nxt  = first_r;
    primed_nxt = primed_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cand_nxt   = '0;
          median_nxt = in_ch.sample_alt;
          first_nxt  = !primed_r;
          primed_nxt = 1'b1;
          state_nxt  = primed_r ? ST_RANK : ST_DONE;
        end
      end
      ST_RANK: begin
        if (cand_hit) begin
          median_nxt = cand_value;
          state_nxt  = ST_MUL;
        end else begin
          cand_nxt = cand_r + 1'b1;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cand_r      <= '0;
      first_r     <= 1'b0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      gain_r      <= GAIN_RESET;
    end else begin
      state_r     <= state_nxt;
      cand_r      <= cand_nxt;
      first_r     <= first_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        gain_r <= cfg_wdata;
      end
    end
  end

  // Payload: hold until the next commit.
  always_ff @(posedge clk) begin
    median_r <= median_nxt;
    if (commit) begin
      out_median_r <= median_r;
      out_smooth_r <= smoothed_nxt;
      out_first_r  <= first_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.median_alt        = out_median_r;
  assign out_ch.smoothed_altitude = out_smooth_r;
  assign out_ch.first_sample      = out_first_r;

  `MTLAF_ASSERT(a_scan_ends, clk, rst_n, (state_r == ST_RANK && cand_r == slot_t'(WINDOW - 1)) |-> cand_hit, "rank scan found no median")
  `MTLAF_ASSERT(a_busy_after_accept, clk, rst_n, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "accepted a beat while busy")
  `MTLAF_ASSERT(a_result_from_commit, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_DONE), "result raised outside commit")

endmodule

// File: verif/altitude_filter_checker.sv
`timescale 1ns / 1ps
module altitude_filter_checker import mtlaf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mtlaf_in_if         in_mon,
  mtlaf_out_if        out_mon,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          error_count,
  output int          pending_count
);

  localparam longint GAIN_UNITY = 64'sd65536;
  localparam int     GAIN_SHIFT = 16;
  localparam int     FRAC_SHIFT = 8;

  typedef struct packed {
    sample_t median;
    sample_t smoothed;
    logic    first;
  } altitude_result_t;

  sample_t          window_q [WINDOW];
  slot_t            next_slot;
  logic             primed;
  acc_t             smooth_acc;
  logic [15:0]      gain;
  altitude_result_t expected_q [$];
  int               mismatches = 0;

  // Rank by value, equal values ranked by slot, so exactly one slot hits TARGET.
  function automatic sample_t window_upper_median();
    int      rank;
    sample_t pick;
    pick = window_q[0];
    for (int i = 0; i < WINDOW; i++) begin
      rank = 0;
      for (int j = 0; j < WINDOW; j++) begin
        if (window_q[j] < window_q[i] || (window_q[j] == window_q[i] && j < i)) rank++;
      end
      if (rank == TARGET) pick = window_q[i];
    end
    return pick;
  endfunction

  function automatic void filter_altitude(input sample_t raw);
    altitude_result_t r;
    longint           mix;
    sample_t          med;
    if (!primed) begin
      for (int i = 0; i < WINDOW; i++) window_q[i] = raw;
      next_slot  = '0;
      smooth_acc = acc_t'({raw, 8'h00});
      primed     = 1'b1;
      med        = raw;
      r.first    = 1'b1;
    end else begin
      window_q[next_slot] = raw;
      next_slot = (next_slot == slot_t'(WINDOW - 1)) ? '0 : next_slot + 1'b1;
      med = window_upper_median();
      // exact sum, then floor divide by 2^16
      mix = longint'(gain) * (longint'(med) <<< FRAC_SHIFT) +
            (GAIN_UNITY - longint'(gain)) * longint'(smooth_acc);
      smooth_acc = acc_t'(mix >>> GAIN_SHIFT);
      r.first    = 1'b0;
    end
    r.median   = med;
    r.smoothed = sample_t'(smooth_acc >>> FRAC_SHIFT);
    expected_q.insert(expected_q.size(), r);
  endfunction

  always @(posedge clk) begin
    altitude_result_t exp_r;
    if (!rst_n) begin
      next_slot  = '0;
      primed     = 1'b0;
      smooth_acc = '0;
      gain       = GAIN_RESET;
      expected_q.delete();
    end else begin
      if (cfg_we) gain = cfg_wdata;
      // results first: a result can never belong to a beat taken at the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing pending: median=%0d smoothed=%0d first=%0b",
                   $time, out_mon.median_alt, out_mon.smoothed_altitude,
                   out_mon.first_sample);
          mismatches++;
        end else begin
          exp_r = expected_q[0];
          expected_q.delete(0);
          if (out_mon.median_alt !== exp_r.median) begin
            $display("%0t: median_alt expected %0d actual %0d",
                     $time, exp_r.median, out_mon.median_alt);
            mismatches++;
          end
          if (out_mon.smoothed_altitude !== exp_r.smoothed) begin
            $display("%0t: smoothed_altitude expected %0d actual %0d",
                     $time, exp_r.smoothed, out_mon.smoothed_altitude);
            mismatches++;
          end
          if (out_mon.first_sample !== exp_r.first) begin
            $display("%0t: first_sample expected %0b actual %0b",
                     $time, exp_r.first, out_mon.first_sample);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) filter_altitude(in_mon.sample_alt);
    end
    error_count   <= mismatches;
    pending_count <= expected_q.size();
  end

endmodule

// File: verif/tb_median_then_lowpass_altitude_filter.sv
`timescale 1ns / 1ps
module tb_median_then_lowpass_altitude_filter import mtlaf_pkg::*; ();

  // The slowest correct run, about 1150 beats with the longest sender gap and
  // receiver stall on each plus the hold-off, stays well inside CYCLE_LIMIT.
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 141;
  localparam int NUM_PHASES      = 8;

  localparam sample_t ALT_MAX = 16'sh7FFF;
  localparam sample_t ALT_MIN = 16'sh8000;

  localparam int RX_RANDOM = 0;
  localparam int RX_ALWAYS = 1;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          error_count;
  int          pending_count;
  int          cycle_count = 0;

  // stimulus shaping, written by the main sequence and read by the drivers
  bit          tx_calm     = 1'b0;
  int          rx_mode     = RX_RANDOM;
  bit          hold_off_req = 1'b0;
  sample_t     trend       = 16'sd2560;   // about 10 m above bottom
  sample_t     last_altitude = '0;

  mtlaf_in_if  in_ch ();
  mtlaf_out_if out_ch ();

  median_then_lowpass_altitude_filter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  altitude_filter_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Sender gaps: mostly back to back, some short, a few long.
  function automatic int tx_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int rx_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Mix of full-range noise, a drifting bottom track with jitter, repeats
  // (ties in the window), rail values and single-bit outliers.
  function automatic sample_t next_altitude();
    int      pick;
    sample_t v;
    pick  = $urandom_range(0, 19);
    trend = trend + sample_t'($urandom_range(0, 64)) - 16'sd32;
    if (pick < 6)       v = sample_t'($urandom());
    else if (pick < 13) v = trend + sample_t'($urandom_range(0, 1023)) - 16'sd512;
    else if (pick < 15) v = last_altitude;
    else if (pick == 15) v = ALT_MAX;
    else if (pick == 16) v = ALT_MIN;
    else                v = trend ^ sample_t'(16'h0001 << $urandom_range(0, 15));
    last_altitude = v;
    return v;
  endfunction

  // Offer one beat and hold it until taken. Leave valid high on return so a
  // back-to-back beat never drops and raises valid in the same step.
  task automatic send_altitude(input sample_t value);
    int gap;
    gap = tx_calm ? 0 : tx_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.sample_alt <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, wait for every pending result, then let the pipe settle.
  task automatic drain_filter();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Gain may only change while the filter is idle.
  task automatic write_gain(input logic [15:0] value);
    drain_filter();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: random ready pattern, a steady-ready mode, and one long hold-off
  // on request while the sender keeps pushing.
  initial begin
    int run;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (rx_mode == RX_ALWAYS) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        run = $urandom_range(1, 12);
        out_ch.ready <= 1'b1;
        repeat (run) @(posedge clk);
        run = rx_stall();
        out_ch.ready <= 1'b0;
        repeat (run) @(posedge clk);
      end
    end
  end

  // Watchdog: count cycles and give up at the limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    sample_t     directed [20];
    logic [15:0] phase_gain [NUM_PHASES];

    // first beat is the negative rail so the accumulator load is checked at
    // its extreme; then rails, sign boundary, alternating bit patterns, a run
    // of equal values and a falling ramp through zero
    directed = '{ALT_MIN, ALT_MAX, ALT_MAX, ALT_MIN, -16'sd1, 16'sd0, 16'sd1,
                 16'sh5555, sample_t'(16'hAAAA), 16'sd256, 16'sd256, 16'sd256,
                 16'sd256, 16'sd256, -16'sd256, 16'sd300, 16'sd200, 16'sd100,
                 16'sd0, -16'sd100};

    // phase 0 runs on the reset gain, the rest write a new one first:
    // zero (accumulator holds), full scale, smallest step, half, reset value
    // written back, and two random gains
    phase_gain = '{GAIN_RESET, 16'd0, 16'hFFFF, 16'd1, 16'h8000, GAIN_RESET,
                   16'($urandom()), 16'($urandom())};

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.sample_alt = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_altitude(directed[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) write_gain(phase_gain[p]);
      // phase 1: stall the receiver hard while the sender streams, so the
      // output register fills and the input backs up
      // phase 3: no idling on either side
      tx_calm = (p == 1) || (p == 3);
      rx_mode = (p == 3) ? RX_ALWAYS : RX_RANDOM;
      if (p == 1) hold_off_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_altitude(next_altitude());
    end

    drain_filter();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
